// File: rtl/asce_pkg.sv
// ----------------------------------------------------------------------------
// asce_pkg
// Shared types and constants of the accumulator machine executor.
// ----------------------------------------------------------------------------
package asce_pkg;

  localparam logic [31:0] LIMIT_AT_RESET = 32'd30000000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STEP  = 2'd1,
    OP_RESET = 2'd2,
    OP_READ  = 2'd3
  } oper_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_PC_OUT  = 3'd2,
    ST_BAD_OP  = 3'd3,
    ST_LIMIT   = 3'd4,
    ST_BAD_ADR = 3'd5
  } stat_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } acc_t;

  typedef enum logic [7:0] {
    OPC_LDC = 8'd0, OPC_ADC = 8'd1, OPC_LDL = 8'd2, OPC_STL = 8'd3,
    OPC_LDNL = 8'd4, OPC_STNL = 8'd5, OPC_ADD = 8'd6, OPC_SUB = 8'd7,
    OPC_SHL = 8'd8, OPC_SHR = 8'd9, OPC_ADJ = 8'd10, OPC_A2SP = 8'd11,
    OPC_SP2A = 8'd12, OPC_CALL = 8'd13, OPC_RET = 8'd14, OPC_BRZ = 8'd15,
    OPC_BRLZ = 8'd16, OPC_BR = 8'd17, OPC_HALT = 8'd18
  } opc_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_WORK, S_FETCH, S_EXEC, S_OUT
  } state_t;

  typedef struct packed {
    logic   clear_step;
    logic   start;
    logic   fetch;
    logic   exec;
    logic   write;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_fetch;
    logic need_write;
  } sts_t;

endpackage

// File: rtl/asce_ctrl.sv
// ----------------------------------------------------------------------------
// asce_ctrl
// Sequencing controller: clearing pass, then one request at a time.
// ----------------------------------------------------------------------------
module asce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  asce_pkg::sts_t  sts,
  output asce_pkg::cmd_t  cmd
);
  import asce_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_WORK;
      S_WORK:  state_next = sts.need_fetch ? S_FETCH : S_OUT;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      S_WORK:  cmd.fetch = 1'b1;
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.write = sts.need_write;
      end
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input and output open together");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_ready) |=> state == S_OUT)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing");
endmodule

// File: rtl/asce_datapath.sv
// ----------------------------------------------------------------------------
// asce_datapath
// Registers, code and data stores, and instruction execution.
// ----------------------------------------------------------------------------
module asce_datapath #(
  parameter int DATA_WORDS = 65536,
  parameter int CODE_WORDS = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  asce_pkg::cmd_t        cmd,
  output asce_pkg::sts_t        sts,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            operation,
  input  logic [31:0]           word,
  input  logic [15:0]           read_address,
  output logic [2:0]            status,
  output logic signed [31:0]    acc_a,
  output logic signed [31:0]    acc_b,
  output logic signed [31:0]    prog_counter,
  output logic signed [31:0]    stack_ptr,
  output logic [1:0]            access_kind,
  output logic [15:0]           access_address,
  output logic signed [31:0]    old_value,
  output logic signed [31:0]    new_value
);
  import asce_pkg::*;

  localparam int DAW = $clog2(DATA_WORDS);
  localparam int CAW = $clog2(CODE_WORDS);
  localparam int LW  = CAW + 1;

  logic [31:0] code_mem [CODE_WORDS];
  logic [31:0] data_mem [DATA_WORDS];

  logic [31:0] execution_limit;
  logic [31:0] reg_a, reg_b, pc_reg, sp_reg, executed_count;
  logic [LW-1:0] code_length;
  logic [DAW-1:0] clr_addr;
  logic [1:0]  op;
  logic [31:0] wd;
  logic [15:0] ra;
  logic [31:0] code_q, data_q;
  logic [DAW-1:0] daddr;
  logic [31:0] wdata;
  logic        wr_en;
  logic [31:0] cnt_next;
  logic        pc_ok, ra_ok;
  logic [7:0]  opc;
  logic [31:0] opd, addr, shr_v, pc_inc, pc_next;
  logic        addr_ok, is_mem;
  logic [4:0]  sh;
  stat_t       fetch_status;

  assign pc_ok = !pc_reg[31] && ({1'b0, pc_reg} < {{(33 - LW){1'b0}}, code_length});
  assign ra_ok = ({17'd0, ra} < 33'(DATA_WORDS));
  assign cnt_next = (executed_count == 32'hFFFF_FFFF) ? executed_count
                                                      : executed_count + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      execution_limit <= LIMIT_AT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      execution_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= operation;
      wd <= word;
      ra <= read_address;
    end
  end

  // Decode of the fetched instruction.
  assign opc = code_q[7:0];
  assign opd = {{8{code_q[31]}}, code_q[31:8]};
  assign addr = ((opc <= OPC_STL) ? sp_reg : reg_a) + opd;
  assign addr_ok = !addr[31] && ({1'b0, addr} < 33'(DATA_WORDS));
  assign is_mem = (opc inside {OPC_LDL, OPC_STL, OPC_LDNL, OPC_STNL});
  assign sh = reg_a[4:0];
  assign shr_v = 32'($signed(reg_b) >>> sh);
  assign pc_inc = pc_reg + 32'd1;

  always_comb begin
    case (opc)
      OPC_CALL, OPC_BR: pc_next = pc_inc + opd;
      OPC_RET:  pc_next = reg_a;
      OPC_BRZ:  pc_next = (reg_a == '0) ? pc_inc + opd : pc_inc;
      OPC_BRLZ: pc_next = reg_a[31] ? pc_inc + opd : pc_inc;
      default:  pc_next = pc_inc;
    endcase
  end

  always_comb begin
    fetch_status = ST_OK;
    if (op == OP_READ && !ra_ok) fetch_status = ST_BAD_ADR;
    else if (op == OP_STEP && !pc_ok) fetch_status = ST_PC_OUT;
    else if (op == OP_STEP && cnt_next > execution_limit) fetch_status = ST_LIMIT;
  end

  assign sts.clear_done = (clr_addr == DAW'(DATA_WORDS - 1));
  assign sts.need_fetch = (op == OP_STEP) && pc_ok && (cnt_next <= execution_limit);
  assign sts.need_write = is_mem && addr_ok && (opc == OPC_STL || opc == OPC_STNL);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Data store address and write selection.
  always_comb begin
    daddr = addr[DAW-1:0];
    wdata = (opc == OPC_STL) ? reg_a : reg_b;
    wr_en = 1'b0;
    if (cmd.clear_step) begin
      daddr = clr_addr;
      wdata = '0;
      wr_en = 1'b1;
    end else if (cmd.start) begin
      daddr = ({17'd0, read_address} < 33'(DATA_WORDS)) ? DAW'(read_address) : '0;
    end else if (cmd.fetch) begin
      wr_en = (op == OP_LOAD) && (code_length < LW'(CODE_WORDS)) &&
              ({{(33 - LW){1'b0}}, code_length} < 33'(DATA_WORDS));
      if (wr_en) begin
        daddr = DAW'(code_length);
        wdata = wd;
      end
    end else if (cmd.write) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) data_mem[daddr] <= wdata;
    data_q <= data_mem[daddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch && op == OP_LOAD && code_length < LW'(CODE_WORDS)) begin
      code_mem[CAW'(code_length)] <= wd;
    end
    code_q <= code_mem[pc_reg[CAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a <= '0; reg_b <= '0; pc_reg <= '0; sp_reg <= '0;
      executed_count <= '0; code_length <= '0;
    end else if (cmd.fetch) begin
      status <= fetch_status;
      access_kind <= ACC_NONE;
      access_address <= (op == OP_READ) ? ra : '0;
      old_value <= '0;
      new_value <= (op == OP_READ && ra_ok) ? data_q : '0;
      case (op)
        OP_LOAD: if (code_length < LW'(CODE_WORDS)) code_length <= code_length + 1'b1;
        OP_RESET: begin
          reg_a <= '0; reg_b <= '0; pc_reg <= '0; sp_reg <= '0;
          executed_count <= '0;
        end
        OP_STEP: if (pc_ok) executed_count <= cnt_next;
        default: ;
      endcase
    end else if (cmd.exec) begin
      if (opc == OPC_HALT) status <= ST_HALT;
      else if (opc > OPC_BR) status <= ST_BAD_OP;
      else if (is_mem && !addr_ok) status <= ST_BAD_ADR;
      else begin
        pc_reg <= pc_next;
        case (opc)
          OPC_LDC: begin reg_b <= reg_a; reg_a <= opd; end
          OPC_ADC: reg_a <= reg_a + opd;
          OPC_LDL, OPC_STL, OPC_LDNL, OPC_STNL: begin
            access_address <= addr[15:0];
          end
          OPC_ADD: reg_a <= reg_b + reg_a;
          OPC_SUB: reg_a <= reg_b - reg_a;
          OPC_SHL: reg_a <= reg_b << sh;
          OPC_SHR: reg_a <= shr_v;
          OPC_ADJ: sp_reg <= sp_reg + opd;
          OPC_A2SP: begin sp_reg <= reg_a; reg_a <= reg_b; end
          OPC_SP2A: begin reg_b <= reg_a; reg_a <= sp_reg; end
          OPC_CALL: begin reg_b <= reg_a; reg_a <= pc_inc; end
          OPC_RET: reg_a <= reg_b;
          default: ;
        endcase
        if (is_mem) begin
          case (opc)
            OPC_LDL: begin
              access_kind <= ACC_READ; reg_b <= reg_a; reg_a <= data_q;
              old_value <= data_q;
            end
            OPC_LDNL: begin
              access_kind <= ACC_READ; reg_a <= data_q; old_value <= data_q;
            end
            OPC_STL: begin
              access_kind <= ACC_WRITE; old_value <= data_q; new_value <= reg_a;
              reg_a <= reg_b;
            end
            default: begin
              access_kind <= ACC_WRITE; old_value <= data_q; new_value <= reg_b;
            end
          endcase
        end
      end
    end
  end

  assign acc_a = reg_a;
  assign acc_b = reg_b;
  assign prog_counter = pc_reg;
  assign stack_ptr = sp_reg;

  assert property (@(posedge clk) disable iff (rst)
    cmd.fetch && op == OP_LOAD |=> code_length >= $past(code_length))
    else $error("code length went back");
  assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> is_mem && addr_ok)
    else $error("write to invalid address");
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(cmd.fetch, 2))
    else $error("execute without fetch");
endmodule

// File: rtl/accumulator_stack_cpu_executor.sv
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_executor
// Two-register accumulator machine with code and data stores.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (operation, word, read_address) and each
// gives one result on the out channel. Load appends a word to the code and
// data stores; step executes one instruction; reset clears the registers;
// read returns one data word. The cfg channel writes the execution limit.
// A load, reset or read, and a step refused at the program counter or the
// limit, is offered as a result once the work state has registered it. A
// step that runs goes on through the registered code fetch, then the
// registered data read, then the execute cycle that also writes the data
// store for a store. One request is handled at a time; the next is taken
// the cycle after the result is taken. After reset the data store is
// cleared one word a cycle, every word of it, while no request is
// accepted. A stalled receiver holds the result on the out channel and
// blocks new requests.
// ----------------------------------------------------------------------------
module accumulator_stack_cpu_executor #(
  parameter int DATA_WORDS = 65536,
  parameter int CODE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [31:0]        word,
  input  logic [15:0]        read_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] acc_a,
  output logic signed [31:0] acc_b,
  output logic signed [31:0] prog_counter,
  output logic signed [31:0] stack_ptr,
  output logic [1:0]         access_kind,
  output logic [15:0]        access_address,
  output logic signed [31:0] old_value,
  output logic signed [31:0] new_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import asce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  asce_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  asce_datapath #(.DATA_WORDS(DATA_WORDS), .CODE_WORDS(CODE_WORDS)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_valid, .cfg_ready, .cfg_data,
    .operation, .word, .read_address, .status, .acc_a, .acc_b,
    .prog_counter, .stack_ptr, .access_kind, .access_address,
    .old_value, .new_value
  );
endmodule
